// ===== rtl/core/tlm_pkg.sv =====
// Shared types, constants and command/status structs for the trie segmenter.
package tlm_pkg;

  localparam int NODE_COUNT  = 256;
  localparam int NODE_W      = 8;
  // trie entry: word-end flag of the child node over the child index
  localparam int ENTRY_W     = NODE_W + 1;
  localparam int SYM_W       = 8;
  localparam int CHILD_AW    = NODE_W + SYM_W;
  localparam int CHILD_DEPTH = 1 << CHILD_AW;
  localparam int MAX_WORD    = 64;
  localparam int LEN_W       = 7;
  localparam int BUF_AW      = 7;
  localparam int BUF_DEPTH   = 1 << BUF_AW;
  localparam int POS_W       = 16;
  localparam int USED_W      = 9;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_DICT  = 2'd1,
    ACT_TEXT  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ST_SEGMENT  = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_LOAD_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [SYM_W-1:0] symbol;
    logic             final_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] segment_start;
    logic [LEN_W-1:0] segment_length;
    logic             text_done;
    logic             last;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_CHK,
    S_WALK_A,
    S_WALK_B,
    S_WALK_C,
    S_EMIT,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_INIT,
    OP_SWEEP,
    OP_LD_SKIP,
    OP_LD_FAIL,
    OP_LD_COMMIT,
    OP_TXT_DROP,
    OP_TXT_PUSH,
    OP_WALK_STEP,
    OP_END_TEXT,
    OP_EMIT,
    OP_SEND
  } op_t;

  typedef struct packed {
    op_t  op;
    logic capture;
    logic rd_walk;
    logic final_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic depth_ok;
    logic err_latched;
    logic sweep_last;
    logic load_ok;
    logic pc_lt_tc;
    logic pc_nz;
    logic fin;
    logic walk_ok;
    logic best_nz;
    logic hold_v;
  } stat_t;

endpackage

// ===== rtl/core/trie_longest_match_segmenter.sv =====
// Top level: greedy longest-match text segmenter over a byte trie.
// One request at a time. A dictionary byte ends on acceptance when skipped, passes the
// load check when stored, goes to the finish state when too long, and does both on a
// full table. A text byte is accepted, each buffered byte walked or tried, each result cut,
// the last one sent, with an end check unless a mismatch ends the walk. Every result send
// is stretched by out_ready. Reset and a clear sweep the trie table; no request taken.
module trie_longest_match_segmenter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tlm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tlm_pkg::out_t out_data
);

  tlm_pkg::cmd_t  cmd;
  tlm_pkg::stat_t stat;

  tlm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tlm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/tlm_dp.sv =====
// Datapath: trie table, text byte buffer, walk/insert registers and result hold.
module tlm_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  tlm_pkg::in_t  in_data,
  input  tlm_pkg::cmd_t cmd,
  output tlm_pkg::stat_t stat,
  output tlm_pkg::out_t out_data
);

  // Memories; the word-end flag of a node rides on the one edge that leads to it
  logic [tlm_pkg::ENTRY_W-1:0] child_mem [tlm_pkg::CHILD_DEPTH];
  logic [tlm_pkg::SYM_W-1:0]   buf_mem   [tlm_pkg::BUF_DEPTH];

  logic [tlm_pkg::ENTRY_W-1:0]  child_q;
  logic [tlm_pkg::NODE_W-1:0]   child_node;
  logic                         child_end;
  logic [tlm_pkg::SYM_W-1:0]    buf_q;
  logic                         child_we;
  logic [tlm_pkg::CHILD_AW-1:0] child_waddr;
  logic [tlm_pkg::CHILD_AW-1:0] child_raddr;
  logic [tlm_pkg::ENTRY_W-1:0]  child_wdata;
  logic                         buf_we;
  logic [tlm_pkg::BUF_AW-1:0]   buf_raddr;
  logic [tlm_pkg::BUF_AW-1:0]   buf_waddr;

  // Registers
  logic [tlm_pkg::SYM_W-1:0]    sym_r, sym_nxt;
  logic                         fin_r, fin_nxt;
  logic [tlm_pkg::CHILD_AW-1:0] sweep_r, sweep_nxt;
  logic [tlm_pkg::USED_W-1:0]   used_r, used_nxt;
  logic [tlm_pkg::NODE_W-1:0]   ins_node_r, ins_node_nxt;
  logic [tlm_pkg::LEN_W-1:0]    ins_depth_r, ins_depth_nxt;
  logic                         skip_r, skip_nxt;
  logic [tlm_pkg::NODE_W-1:0]   walk_node_r, walk_node_nxt;
  logic [tlm_pkg::LEN_W-1:0]    pc_r, pc_nxt;
  logic [tlm_pkg::LEN_W-1:0]    tc_r, tc_nxt;
  logic [tlm_pkg::LEN_W-1:0]    best_r, best_nxt;
  logic [tlm_pkg::POS_W-1:0]    cs_r, cs_nxt;
  logic                         err_r, err_nxt;
  logic                         hold_v_r, hold_v_nxt;
  logic [1:0]                   hold_st_r, hold_st_nxt;
  logic [tlm_pkg::POS_W-1:0]    hold_start_r, hold_start_nxt;
  logic [tlm_pkg::LEN_W-1:0]    hold_len_r, hold_len_nxt;
  logic                         hold_done_r, hold_done_nxt;

  logic [tlm_pkg::SYM_W-1:0]  cur_sym;
  logic                       cur_fin;
  logic [tlm_pkg::NODE_W-1:0] new_node;

  assign child_node = child_q[tlm_pkg::NODE_W-1:0];
  assign child_end  = child_q[tlm_pkg::NODE_W];
  assign cur_sym  = cmd.capture ? in_data.symbol : sym_r;
  assign cur_fin  = cmd.capture ? in_data.final_byte : fin_r;
  assign new_node = (child_node != '0) ? child_node : used_r[tlm_pkg::NODE_W-1:0];

  // Addresses; buffer is circular over text positions
  assign child_raddr = cmd.rd_walk ? {walk_node_r, buf_q} : {ins_node_r, cur_sym};
  assign buf_raddr   = cs_r[tlm_pkg::BUF_AW-1:0] + pc_r;
  assign buf_waddr   = cs_r[tlm_pkg::BUF_AW-1:0] + tc_r;

  always_ff @(posedge clk) begin
    child_q <= child_mem[child_raddr];
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
  end

  always_ff @(posedge clk) begin
    buf_q <= buf_mem[buf_raddr];
    if (buf_we) begin
      buf_mem[buf_waddr] <= cur_sym;
    end
  end

  // Status to the controller
  always_comb begin
    stat.skip        = skip_r;
    stat.depth_ok    = (ins_depth_r < tlm_pkg::LEN_W'(tlm_pkg::MAX_WORD - 1)) || cur_fin;
    stat.err_latched = err_r;
    stat.sweep_last  = &sweep_r;
    stat.load_ok     = (child_node != '0) ||
                       (used_r < tlm_pkg::USED_W'(tlm_pkg::NODE_COUNT));
    stat.pc_lt_tc    = pc_r < tc_r;
    stat.pc_nz       = pc_r != '0;
    stat.fin         = fin_r;
    stat.walk_ok     = (pc_r < tlm_pkg::LEN_W'(tlm_pkg::MAX_WORD)) && (child_node != '0);
    stat.best_nz     = best_r != '0;
    stat.hold_v      = hold_v_r;
  end

  // Result payload
  always_comb begin
    out_data.status         = hold_st_r;
    out_data.segment_start  = hold_start_r;
    out_data.segment_length = hold_len_r;
    out_data.text_done      = cmd.final_out & hold_done_r;
    out_data.last           = cmd.final_out;
  end

  // Next-state logic for all datapath registers
  always_comb begin
    sym_nxt        = sym_r;
    fin_nxt        = fin_r;
    sweep_nxt      = sweep_r;
    used_nxt       = used_r;
    ins_node_nxt   = ins_node_r;
    ins_depth_nxt  = ins_depth_r;
    skip_nxt       = skip_r;
    walk_node_nxt  = walk_node_r;
    pc_nxt         = pc_r;
    tc_nxt         = tc_r;
    best_nxt       = best_r;
    cs_nxt         = cs_r;
    err_nxt        = err_r;
    hold_v_nxt     = hold_v_r;
    hold_st_nxt    = hold_st_r;
    hold_start_nxt = hold_start_r;
    hold_len_nxt   = hold_len_r;
    hold_done_nxt  = hold_done_r;
    child_we       = 1'b0;
    child_waddr    = sweep_r;
    child_wdata    = '0;
    buf_we         = 1'b0;

    if (cmd.capture) begin
      sym_nxt = in_data.symbol;
      fin_nxt = in_data.final_byte;
    end

    case (cmd.op)
      tlm_pkg::OP_CLR_INIT: begin
        used_nxt      = tlm_pkg::USED_W'(1);
        ins_node_nxt  = '0;
        ins_depth_nxt = '0;
        skip_nxt      = 1'b0;
        walk_node_nxt = '0;
        pc_nxt        = '0;
        tc_nxt        = '0;
        best_nxt      = '0;
        cs_nxt        = '0;
        err_nxt       = 1'b0;
        hold_v_nxt    = 1'b0;
        sweep_nxt     = '0;
      end
      tlm_pkg::OP_SWEEP: begin
        child_we  = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
      end
      tlm_pkg::OP_LD_SKIP: begin
        if (cur_fin) begin
          ins_node_nxt  = '0;
          ins_depth_nxt = '0;
          skip_nxt      = 1'b0;
        end
      end
      tlm_pkg::OP_LD_FAIL: begin
        if (cur_fin) begin
          ins_node_nxt  = '0;
          ins_depth_nxt = '0;
          skip_nxt      = 1'b0;
        end else begin
          skip_nxt = 1'b1;
        end
        hold_v_nxt     = 1'b1;
        hold_st_nxt    = tlm_pkg::ST_LOAD_ERR;
        hold_start_nxt = '0;
        hold_len_nxt   = '0;
        hold_done_nxt  = 1'b0;
      end
      tlm_pkg::OP_LD_COMMIT: begin
        // allocate a fresh node when the edge is missing; a final byte marks the edge
        child_we    = (child_node == '0) || fin_r;
        child_waddr = {ins_node_r, sym_r};
        child_wdata = {child_end | fin_r, new_node};
        if (child_node == '0) begin
          used_nxt = used_r + 1'b1;
        end
        ins_node_nxt  = new_node;
        ins_depth_nxt = ins_depth_r + 1'b1;
        if (fin_r) begin
          ins_node_nxt  = '0;
          ins_depth_nxt = '0;
          skip_nxt      = 1'b0;
        end
      end
      tlm_pkg::OP_TXT_DROP: begin
        if (cur_fin) begin
          walk_node_nxt = '0;
          pc_nxt        = '0;
          tc_nxt        = '0;
          best_nxt      = '0;
          cs_nxt        = '0;
          err_nxt       = 1'b0;
        end
      end
      tlm_pkg::OP_TXT_PUSH: begin
        buf_we = 1'b1;
        tc_nxt = tc_r + 1'b1;
      end
      tlm_pkg::OP_WALK_STEP: begin
        pc_nxt        = pc_r + 1'b1;
        walk_node_nxt = child_node;
        if (child_end) begin
          best_nxt = pc_r + 1'b1;
        end
      end
      tlm_pkg::OP_END_TEXT: begin
        if (fin_r) begin
          walk_node_nxt = '0;
          pc_nxt        = '0;
          tc_nxt        = '0;
          best_nxt      = '0;
          cs_nxt        = '0;
          err_nxt       = 1'b0;
        end
      end
      tlm_pkg::OP_EMIT: begin
        hold_v_nxt     = 1'b1;
        hold_start_nxt = cs_r;
        hold_done_nxt  = fin_r;
        walk_node_nxt  = '0;
        pc_nxt         = '0;
        best_nxt       = '0;
        if (best_r != '0) begin
          // cut the segment; unmatched bytes stay in the buffer for re-feed
          hold_st_nxt  = tlm_pkg::ST_SEGMENT;
          hold_len_nxt = best_r;
          cs_nxt       = cs_r + tlm_pkg::POS_W'(best_r);
          tc_nxt       = tc_r - best_r;
        end else begin
          hold_st_nxt  = tlm_pkg::ST_MISMATCH;
          hold_len_nxt = '0;
          tc_nxt       = '0;
          if (fin_r) begin
            cs_nxt  = '0;
            err_nxt = 1'b0;
          end else begin
            err_nxt = 1'b1;
          end
        end
      end
      tlm_pkg::OP_SEND: begin
        hold_v_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      used_r      <= tlm_pkg::USED_W'(1);
      ins_node_r  <= '0;
      ins_depth_r <= '0;
      skip_r      <= 1'b0;
      walk_node_r <= '0;
      pc_r        <= '0;
      tc_r        <= '0;
      best_r      <= '0;
      cs_r        <= '0;
      err_r       <= 1'b0;
      hold_v_r    <= 1'b0;
    end else begin
      sweep_r     <= sweep_nxt;
      used_r      <= used_nxt;
      ins_node_r  <= ins_node_nxt;
      ins_depth_r <= ins_depth_nxt;
      skip_r      <= skip_nxt;
      walk_node_r <= walk_node_nxt;
      pc_r        <= pc_nxt;
      tc_r        <= tc_nxt;
      best_r      <= best_nxt;
      cs_r        <= cs_nxt;
      err_r       <= err_nxt;
      hold_v_r    <= hold_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sym_r        <= sym_nxt;
    fin_r        <= fin_nxt;
    hold_st_r    <= hold_st_nxt;
    hold_start_r <= hold_start_nxt;
    hold_len_r   <= hold_len_nxt;
    hold_done_r  <= hold_done_nxt;
  end

endmodule

// ===== rtl/core/tlm_ctrl.sv =====
// Controller state machine: sequences clear sweep, dictionary load and text walk.
module tlm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  tlm_pkg::in_t   in_data,
  input  logic           out_ready,
  input  tlm_pkg::stat_t stat,
  output logic           in_ready,
  output logic           out_valid,
  output tlm_pkg::cmd_t  cmd
);

  tlm_pkg::state_t state_r, state_nxt;

  // State register; reset starts a sweep of the trie table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlm_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.op        = tlm_pkg::OP_NONE;
    cmd.capture   = 1'b0;
    cmd.rd_walk   = 1'b0;
    cmd.final_out = 1'b0;

    unique case (state_r)
      tlm_pkg::S_CLEAR: begin
        cmd.op = tlm_pkg::OP_SWEEP;
        if (stat.sweep_last) begin
          state_nxt = tlm_pkg::S_IDLE;
        end
      end
      tlm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (tlm_pkg::act_t'(in_data.action))
            tlm_pkg::ACT_CLEAR: begin
              cmd.op    = tlm_pkg::OP_CLR_INIT;
              state_nxt = tlm_pkg::S_CLEAR;
            end
            tlm_pkg::ACT_DICT: begin
              if (stat.skip) begin
                cmd.op = tlm_pkg::OP_LD_SKIP;
              end else if (stat.depth_ok) begin
                state_nxt = tlm_pkg::S_LOAD_CHK;
              end else begin
                cmd.op    = tlm_pkg::OP_LD_FAIL;
                state_nxt = tlm_pkg::S_FINISH;
              end
            end
            tlm_pkg::ACT_TEXT: begin
              if (stat.err_latched) begin
                cmd.op = tlm_pkg::OP_TXT_DROP;
              end else begin
                cmd.op    = tlm_pkg::OP_TXT_PUSH;
                state_nxt = tlm_pkg::S_WALK_A;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tlm_pkg::S_LOAD_CHK: begin
        if (stat.load_ok) begin
          cmd.op    = tlm_pkg::OP_LD_COMMIT;
          state_nxt = tlm_pkg::S_IDLE;
        end else begin
          cmd.op    = tlm_pkg::OP_LD_FAIL;
          state_nxt = tlm_pkg::S_FINISH;
        end
      end
      tlm_pkg::S_WALK_A: begin
        if (stat.pc_lt_tc) begin
          state_nxt = tlm_pkg::S_WALK_B;
        end else if (stat.fin && stat.pc_nz) begin
          state_nxt = tlm_pkg::S_EMIT;
        end else begin
          cmd.op    = tlm_pkg::OP_END_TEXT;
          state_nxt = tlm_pkg::S_FINISH;
        end
      end
      tlm_pkg::S_WALK_B: begin
        // buffered byte is ready; look up its edge
        cmd.rd_walk = 1'b1;
        state_nxt   = tlm_pkg::S_WALK_C;
      end
      tlm_pkg::S_WALK_C: begin
        if (stat.walk_ok) begin
          cmd.op    = tlm_pkg::OP_WALK_STEP;
          state_nxt = tlm_pkg::S_WALK_A;
        end else begin
          state_nxt = tlm_pkg::S_EMIT;
        end
      end
      tlm_pkg::S_EMIT: begin
        // send the previous result before holding the new one
        out_valid = stat.hold_v;
        if (!stat.hold_v || out_ready) begin
          cmd.op    = tlm_pkg::OP_EMIT;
          state_nxt = stat.best_nz ? tlm_pkg::S_WALK_A : tlm_pkg::S_FINISH;
        end
      end
      tlm_pkg::S_FINISH: begin
        cmd.final_out = 1'b1;
        out_valid     = stat.hold_v;
        if (!stat.hold_v) begin
          state_nxt = tlm_pkg::S_IDLE;
        end else if (out_ready) begin
          cmd.op    = tlm_pkg::OP_SEND;
          state_nxt = tlm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tlm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the trie longest-match segmenter: predictor, driver, monitor.
module tb;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int TAIL_CYCLES    = 400;
  // the one action code the block has no name for
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  typedef struct {
    tlm_pkg::in_t d;
    bit           drain;
  } req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tlm_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tlm_pkg::out_t out_data;

  req_t          req_q[$];
  tlm_pkg::out_t seg_exp_q[$];
  int   fail_count = 0;
  int   seg_seen = 0, mism_seen = 0, lerr_seen = 0, req_taken = 0;
  int   quiet_cycles = 0;
  int   in_idle = 0, out_idle = 0;

  // predictor state
  logic [7:0] trie_child[tlm_pkg::CHILD_DEPTH];
  bit         trie_end[tlm_pkg::NODE_COUNT];
  int         used_nodes, ins_node, ins_depth;
  bit         ins_skip;
  logic [7:0] walk_buf[tlm_pkg::MAX_WORD];
  int         walk_cnt, walk_node, walk_best, text_pos;
  bit         text_err;

  trie_longest_match_segmenter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic void walk_reset();
    walk_cnt = 0;
    walk_node = 0;
    walk_best = 0;
  endfunction

  function automatic void text_reset();
    walk_reset();
    text_pos = 0;
    text_err = 0;
  endfunction

  function automatic void dict_clear();
    for (int i = 0; i < tlm_pkg::CHILD_DEPTH; i++) trie_child[i] = '0;
    for (int i = 0; i < tlm_pkg::NODE_COUNT; i++) trie_end[i] = 0;
    used_nodes = 1;
    ins_node = 0;
    ins_depth = 0;
    ins_skip = 0;
    text_reset();
  endfunction

  function automatic bit walk_one(logic [7:0] b);
    int nxt;
    if (walk_cnt >= tlm_pkg::MAX_WORD) return 0;
    nxt = trie_child[{walk_node[7:0], b}];
    if (nxt == 0) return 0;
    walk_buf[walk_cnt] = b;
    walk_cnt++;
    walk_node = nxt;
    if (trie_end[nxt]) walk_best = walk_cnt;
    return 1;
  endfunction

  function automatic tlm_pkg::out_t mk_res(tlm_pkg::status_t st, int start, int len, bit done);
    tlm_pkg::out_t r;
    r.status = st;
    r.segment_start = start[15:0];
    r.segment_length = len[6:0];
    r.text_done = done;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void predict_dict(logic [7:0] sym, bit fin, ref tlm_pkg::out_t res[$]);
    int nxt;
    if (ins_skip) begin
      if (fin) begin
        ins_node = 0; ins_depth = 0; ins_skip = 0;
      end
      return;
    end
    nxt = 0;
    if (ins_depth + 1 < tlm_pkg::MAX_WORD || fin) begin
      nxt = trie_child[{ins_node[7:0], sym}];
      if (nxt == 0 && used_nodes < tlm_pkg::NODE_COUNT) begin
        nxt = used_nodes;
        used_nodes++;
        trie_child[{ins_node[7:0], sym}] = nxt[7:0];
      end
    end
    if (nxt == 0) begin
      if (fin) begin
        ins_node = 0; ins_depth = 0; ins_skip = 0;
      end else ins_skip = 1;
      res = {res, mk_res(tlm_pkg::ST_LOAD_ERR, 0, 0, 0)};
      return;
    end
    ins_node = nxt;
    ins_depth++;
    if (fin) begin
      trie_end[nxt] = 1;
      ins_node = 0; ins_depth = 0; ins_skip = 0;
    end
  endfunction

  function automatic void predict_text(logic [7:0] sym, bit fin, ref tlm_pkg::out_t res[$]);
    logic [7:0] pend[$];
    logic [7:0] fresh[$];
    if (text_err) begin
      if (fin) text_reset();
      return;
    end
    pend = {pend, sym};
    forever begin
      while (pend.size() > 0 && walk_one(pend[0])) void'(pend.pop_front());
      if (pend.size() == 0 && !(fin && walk_cnt > 0)) break;
      if (walk_best == 0) begin
        res = {res, mk_res(tlm_pkg::ST_MISMATCH, text_pos, 0, fin)};
        if (fin) text_reset();
        else begin
          walk_reset();
          text_err = 1;
        end
        return;
      end
      res = {res, mk_res(tlm_pkg::ST_SEGMENT, text_pos, walk_best, 0)};
      text_pos = (text_pos + walk_best) % 65536;
      // bytes read past the match go back in front of the unread ones
      fresh = {};
      for (int i = walk_best; i < walk_cnt; i++) fresh = {fresh, walk_buf[i]};
      pend = {fresh, pend};
      walk_reset();
    end
    if (fin) begin
      if (res.size() > 0) res[res.size()-1].text_done = 1'b1;
      text_reset();
    end
  endfunction

  function automatic void predict_request(tlm_pkg::in_t it);
    tlm_pkg::out_t res[$];
    case (it.action)
      tlm_pkg::ACT_CLEAR: dict_clear();
      tlm_pkg::ACT_DICT:  predict_dict(it.symbol, it.final_byte, res);
      tlm_pkg::ACT_TEXT:  predict_text(it.symbol, it.final_byte, res);
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) seg_exp_q = {seg_exp_q, res[i]};
  endfunction

  // ---------------- checking ----------------
  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  task automatic check_result(tlm_pkg::out_t got);
    tlm_pkg::out_t want;
    if (seg_exp_q.size() == 0) begin
      report("unexpected result, status", got.status, -1);
      return;
    end
    want = seg_exp_q.pop_front();
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.segment_start != want.segment_start)
      report("segment_start", got.segment_start, want.segment_start);
    if (got.segment_length != want.segment_length)
      report("segment_length", got.segment_length, want.segment_length);
    if (got.text_done != want.text_done) report("text_done", got.text_done, want.text_done);
    if (got.last != want.last) report("last", got.last, want.last);
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (req_q.size() > 0 && req_q[0].drain) begin
        in_valid <= 1'b0;
        if (!in_valid && seg_exp_q.size() == 0) void'(req_q.pop_front());
      end else if (in_idle > 0) begin
        in_idle <= in_idle - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() > 40 && $urandom_range(0, 9) == 0) begin
        in_idle <= $urandom_range(1, 17);
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        in_data <= req_q[0].d;
        in_valid <= 1'b1;
        void'(req_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_idle > 0) begin
      out_idle <= out_idle - 1;
      out_ready <= 1'b0;
    end else if (req_q.size() > 40 && $urandom_range(0, 7) == 0) begin
      out_idle <= $urandom_range(1, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------- monitor and watchdog ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_request(in_data);
        req_taken++;
      end
      if (out_valid && out_ready) begin
        case (out_data.status)
          tlm_pkg::ST_SEGMENT:  seg_seen++;
          tlm_pkg::ST_MISMATCH: mism_seen++;
          default:              lerr_seen++;
        endcase
        check_result(out_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", seg_exp_q.size());
        $display("trie_longest_match_segmenter verification failed");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_req(logic [1:0] act, logic [7:0] sym, bit fin);
    req_t r;
    r.d.action = act;
    r.d.symbol = sym;
    r.d.final_byte = fin;
    r.drain = 0;
    req_q = {req_q, r};
  endtask

  task automatic add_drain();
    req_t r;
    r.d = '0;
    r.drain = 1;
    req_q = {req_q, r};
  endtask

  function automatic logic [7:0] pick_sym(bit wide);
    if (wide) return 8'($urandom_range(0, 255));
    return 8'(8'h61 + $urandom_range(0, 3));
  endfunction

  task automatic add_word(int len, bit wide);
    for (int i = 0; i < len; i++) add_req(tlm_pkg::ACT_DICT, pick_sym(wide), i == len - 1);
  endtask

  task automatic add_text(int len, bit wide);
    for (int i = 0; i < len; i++)
      add_req(tlm_pkg::ACT_TEXT, pick_sym(wide && $urandom_range(0, 5) == 0), i == len - 1);
  endtask

  initial begin
    int n_clears;
    int k;
    dict_clear();
    // directed: words a, ab, abc, b; extremes of the symbol byte
    add_req(tlm_pkg::ACT_DICT, 8'h61, 1);
    add_req(tlm_pkg::ACT_DICT, 8'h61, 0); add_req(tlm_pkg::ACT_DICT, 8'h62, 1);
    add_req(tlm_pkg::ACT_DICT, 8'h61, 0); add_req(tlm_pkg::ACT_DICT, 8'h62, 0);
    add_req(tlm_pkg::ACT_DICT, 8'h63, 1);
    add_req(tlm_pkg::ACT_DICT, 8'h62, 1);
    add_req(tlm_pkg::ACT_DICT, 8'h00, 1);
    add_req(tlm_pkg::ACT_DICT, 8'hff, 1);
    add_req(ACT_UNKNOWN, 8'h55, 1);
    // "ababa" then final "c": several cuts, re-fed bytes
    add_req(tlm_pkg::ACT_TEXT, 8'h61, 0); add_req(tlm_pkg::ACT_TEXT, 8'h62, 0);
    add_req(tlm_pkg::ACT_TEXT, 8'h61, 0); add_req(tlm_pkg::ACT_TEXT, 8'h62, 0);
    add_req(tlm_pkg::ACT_TEXT, 8'h61, 0); add_req(tlm_pkg::ACT_TEXT, 8'h63, 1);
    add_req(tlm_pkg::ACT_TEXT, 8'hff, 0); add_req(tlm_pkg::ACT_TEXT, 8'h00, 1);
    // mismatch mid text, ignored bytes, mismatch on the final byte
    add_req(tlm_pkg::ACT_TEXT, 8'h61, 0); add_req(tlm_pkg::ACT_TEXT, 8'h7a, 0);
    add_req(tlm_pkg::ACT_TEXT, 8'h61, 0); add_req(tlm_pkg::ACT_TEXT, 8'h61, 1);
    add_req(tlm_pkg::ACT_TEXT, 8'h7a, 1);
    add_drain();
    // word too long: 65 bytes without final, then its final byte
    for (int i = 0; i < 66; i++) add_req(tlm_pkg::ACT_DICT, 8'h30 + i[5:0], i == 65);
    add_drain();
    // random part: phases of dictionary loading and text
    n_clears = 0;
    k = 0;
    while (req_q.size() < 350) begin
      if (k > 0 && k % 3 == 0 && n_clears < 3) begin
        add_req(tlm_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        n_clears++;
      end
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 7) == 0) add_word($urandom_range(30, 70), 1);
        else add_word($urandom_range(1, 4), $urandom_range(0, 5) == 0);
      end
      repeat ($urandom_range(2, 5)) add_text($urandom_range(1, 12), 1);
      // noise: unknown action; clears are kept rare to save sweeps
      if ($urandom_range(0, 3) == 0) add_req(ACT_UNKNOWN, 8'($urandom_range(0, 255)), 1);
      if (k == 4) add_drain();
      k++;
    end
    // tail: narrow-symbol text, no idling once 40 or fewer requests remain
    repeat (6) add_text($urandom_range(2, 10), 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (req_q.size() > 0 || in_valid) @(posedge clk);
    while (seg_exp_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d clears: %0d segments, %0d mismatches, %0d load errors",
             req_taken, n_clears, seg_seen, mism_seen, lerr_seen);
    $display("%0d results left unmatched, %0d mismatching fields", seg_exp_q.size(), fail_count);
    if (fail_count == 0 && seg_exp_q.size() == 0) begin
      $display("trie_longest_match_segmenter verification clean");
    end else begin
      $display("trie_longest_match_segmenter verification failed");
    end
    $finish;
  end

endmodule
